FILE: sv/text_lcd_cursor_nibble_writer_core_defines.svh
// Assertion helpers for the character display writer.
`ifndef TEXT_LCD_CURSOR_NIBBLE_WRITER_CORE_DEFINES_SVH
`define TEXT_LCD_CURSOR_NIBBLE_WRITER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LCDNW_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LCDNW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/lcdnw_pkg.sv
package lcdnw_pkg;

    // Field widths of the channels.
    localparam int OP_W    = 2;
    localparam int CODE_W  = 8;
    localparam int LINE_W  = 3;
    localparam int COL_W   = 5;
    localparam int NIB_W   = 4;
    localparam int OUTC_W  = 2;
    localparam int ADDR_W  = 7;
    localparam int CFG_IDX_W = 2;

    // Default geometry.
    localparam int DEF_COLUMNS   = 20;
    localparam int DEF_LINES     = 4;
    localparam int DEF_TAB_WIDTH = 4;

    // Reset values of the line base addresses.
    localparam logic [ADDR_W-1:0] BASE_ONE_RST   = 7'd0;
    localparam logic [ADDR_W-1:0] BASE_TWO_RST   = 7'd64;
    localparam logic [ADDR_W-1:0] BASE_THREE_RST = 7'd20;
    localparam logic [ADDR_W-1:0] BASE_FOUR_RST  = 7'd84;

    // Character and command codes.
    localparam logic [CODE_W-1:0] CHAR_TAB     = 8'd9;
    localparam logic [CODE_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CODE_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CODE_W-1:0] CMD_SET_ADDR = 8'h80;

    typedef enum logic [OP_W-1:0] {
        OP_PRINT  = 2'd0,
        OP_CURSOR = 2'd1,
        OP_RAW    = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [OUTC_W-1:0] {
        OUTC_XFER   = 2'd0,
        OUTC_CLIP   = 2'd1,
        OUTC_REJECT = 2'd2
    } t_outcome;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_ONE   = 2'd0,
        REG_LINE_TWO   = 2'd1,
        REG_LINE_THREE = 2'd2,
        REG_LINE_FOUR  = 2'd3
    } t_reg;

endpackage

FILE: sv/lcdnw_in_if.sv
interface lcdnw_in_if import lcdnw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [CODE_W-1:0] char_code;
    logic [LINE_W-1:0] target_line;
    logic [COL_W-1:0]  target_column;

    modport source (output valid, operation, char_code, target_line, target_column,
                    input ready);
    modport sink (input valid, operation, char_code, target_line, target_column,
                  output ready);
endinterface

FILE: sv/lcdnw_out_if.sv
interface lcdnw_out_if import lcdnw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [NIB_W-1:0]  nibble;
    logic              register_select;
    logic [OUTC_W-1:0] outcome;
    logic              last;
    logic [LINE_W-1:0] cursor_line;
    logic [COL_W-1:0]  cursor_column;

    modport source (output valid, nibble, register_select, outcome, last, cursor_line,
                    cursor_column, input ready);
    modport sink (input valid, nibble, register_select, outcome, last, cursor_line,
                  cursor_column, output ready);
endinterface

FILE: sv/text_lcd_cursor_nibble_writer_core.sv
// Character display writer for a 4-bit bus. Each input word prints a character, moves
// the cursor to a line and column, or sends a raw instruction byte; every byte leaves
// as two output words, high nibble first, tagged instruction or data, and each output
// word carries the cursor position after its input. Output runs at one word per cycle
// while not stalled, from a single result register: a byte leaves as two words, a tab
// as 2*TAB_WIDTH, a clipped character or rejected cursor request as one status word;
// the next input is taken in the same cycle that the last word of the current one is
// taken. Operation code 3 is accepted and produces nothing. The user must write line
// base addresses via the configuration port only while idle; the block won't check.
`include "text_lcd_cursor_nibble_writer_core_defines.svh"

module text_lcd_cursor_nibble_writer_core import lcdnw_pkg::*; #(
    parameter int COLUMNS   = DEF_COLUMNS,
    parameter int LINES     = DEF_LINES,
    parameter int TAB_WIDTH = DEF_TAB_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    lcdnw_in_if.sink             i_in,
    lcdnw_out_if.source          o_out
);

    // Column register must hold the parked value and at least the port width.
    localparam int CW = ($clog2(COLUMNS + 2) > COL_W) ? $clog2(COLUMNS + 2) : COL_W;
    localparam int IW = $clog2(2 * TAB_WIDTH);

    localparam logic [CW-1:0]     COL_PARK  = CW'(COLUMNS + 1);
    localparam logic [CW-1:0]     COL_MAX   = CW'(COLUMNS);
    localparam logic [LINE_W-1:0] LINE_MAX  = LINE_W'(LINES);
    localparam logic [IW-1:0]     IDX_BYTE  = IW'(1);
    localparam logic [IW-1:0]     IDX_TAB   = IW'(2 * TAB_WIDTH - 1);

    logic [ADDR_W-1:0] r_base_one, r_base_two, r_base_three, r_base_four;
    logic [LINE_W-1:0] r_line, n_line;
    logic [CW-1:0]     r_col, n_col;

    logic              r_busy;
    logic [IW-1:0]     r_idx;
    logic [IW-1:0]     r_last_idx, n_last_idx;
    logic [CODE_W-1:0] r_byte, n_byte;
    logic              r_rs, n_rs;
    t_outcome          r_outc, n_outc;
    logic              n_load;

    logic              w_accept, w_take, w_last;

    // Cursor request, either from the input or from a newline.
    logic [LINE_W-1:0] w_req_y;
    logic [COL_W-1:0]  w_req_x;
    logic              w_req_line_ok, w_req_col_ok;
    logic [ADDR_W-1:0] w_req_base, w_req_addr;
    logic              w_line_ok;
    logic [CW:0]       w_tab_end;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_one   <= BASE_ONE_RST;
            r_base_two   <= BASE_TWO_RST;
            r_base_three <= BASE_THREE_RST;
            r_base_four  <= BASE_FOUR_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_idx))
                REG_LINE_ONE:   r_base_one   <= i_cfg_data;
                REG_LINE_TWO:   r_base_two   <= i_cfg_data;
                REG_LINE_THREE: r_base_three <= i_cfg_data;
                REG_LINE_FOUR:  r_base_four  <= i_cfg_data;
                default:        r_base_one   <= r_base_one;
            endcase
        end
    end

    // Handshake: a new word may enter while the last result word leaves.
    assign w_last   = (r_idx == r_last_idx);
    assign w_take   = r_busy && o_out.ready;
    assign i_in.ready = !r_busy || (o_out.ready && w_last);
    assign w_accept = i_in.valid && i_in.ready;

    // Cursor request decode and address sum.
    always_comb begin
        if (t_op'(i_in.operation) == OP_CURSOR) begin
            w_req_y = i_in.target_line;
            w_req_x = i_in.target_column;
        end else begin
            w_req_y = r_line + LINE_W'(1);
            w_req_x = COL_W'(1);
        end
        w_req_line_ok = (w_req_y >= LINE_W'(1)) && (w_req_y <= LINE_MAX);
        w_req_col_ok  = (w_req_x != '0) && (CW'(w_req_x) <= COL_MAX);
        case (w_req_y)
            LINE_W'(1): w_req_base = r_base_one;
            LINE_W'(2): w_req_base = r_base_two;
            LINE_W'(3): w_req_base = r_base_three;
            default:    w_req_base = r_base_four;
        endcase
        w_req_addr = w_req_base + ADDR_W'(w_req_x) - ADDR_W'(1);
        w_line_ok  = (r_line <= LINE_MAX);
        w_tab_end  = {1'b0, r_col} + (CW+1)'(TAB_WIDTH);
    end

    // Work out the whole result of one input word.
    always_comb begin
        n_load     = 1'b0;
        n_byte     = '0;
        n_rs       = 1'b0;
        n_outc     = OUTC_XFER;
        n_last_idx = '0;
        n_line     = r_line;
        n_col      = r_col;
        unique case (t_op'(i_in.operation))
            OP_CURSOR, OP_PRINT: begin
                n_load = 1'b1;
                if (t_op'(i_in.operation) == OP_CURSOR || i_in.char_code == CHAR_NEWLINE) begin
                    if (w_req_line_ok && w_req_col_ok) begin
                        n_line     = w_req_y;
                        n_col      = CW'(w_req_x);
                        n_byte     = CMD_SET_ADDR | CODE_W'(w_req_addr);
                        n_last_idx = IDX_BYTE;
                    end else begin
                        n_line = w_req_line_ok ? w_req_y : LINE_MAX;
                        n_col  = COL_PARK;
                        n_outc = OUTC_REJECT;
                    end
                end else if (i_in.char_code == CHAR_TAB) begin
                    if (w_line_ok && (w_tab_end <= (CW+1)'(COLUMNS))) begin
                        n_byte     = CHAR_SPACE;
                        n_rs       = 1'b1;
                        n_last_idx = IDX_TAB;
                        n_col      = w_tab_end[CW-1:0];
                    end else begin
                        n_outc = OUTC_CLIP;
                    end
                end else if (w_line_ok && (r_col <= COL_MAX)) begin
                    n_byte     = i_in.char_code;
                    n_rs       = 1'b1;
                    n_last_idx = IDX_BYTE;
                    n_col      = r_col + CW'(1);
                end else begin
                    n_outc = OUTC_CLIP;
                end
            end
            OP_RAW: begin
                n_load     = 1'b1;
                n_byte     = i_in.char_code;
                n_last_idx = IDX_BYTE;
            end
            OP_NONE: begin
                n_load = 1'b0;
            end
            default: begin
                n_load = 1'b0;
            end
        endcase
    end

    // Cursor state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= LINE_W'(1);
            r_col  <= CW'(1);
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            if (w_accept) begin
                r_line <= n_line;
                r_col  <= n_col;
            end
            if (w_accept) begin
                r_busy <= n_load;
                r_idx  <= '0;
            end else if (w_take) begin
                if (w_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + IW'(1);
                end
            end
        end
    end

    // Payload of the result register needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept && n_load) begin
            r_byte     <= n_byte;
            r_rs       <= n_rs;
            r_outc     <= n_outc;
            r_last_idx <= n_last_idx;
        end
    end

    // Even index sends the high nibble, odd the low one.
    assign o_out.valid           = r_busy;
    assign o_out.nibble          = r_idx[0] ? r_byte[NIB_W-1:0] : r_byte[CODE_W-1:NIB_W];
    assign o_out.register_select = r_rs;
    assign o_out.outcome         = r_outc;
    assign o_out.last            = w_last;
    assign o_out.cursor_line     = r_line;
    assign o_out.cursor_column   = r_col[COL_W-1:0];

    // A word in the middle of its item keeps the output valid.
    `LCDNW_ASSERT_NEXT(a_hold_mid_item, i_clk, i_rst_n, o_out.valid && o_out.ready && !o_out.last, o_out.valid, "result sequence cut short")
    // A new word is taken over a busy output only as its last result leaves.
    `LCDNW_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, w_accept && r_busy, o_out.ready && o_out.last, "result overwritten")
    // Status reports are single, empty words.
    `LCDNW_ASSERT_IMPL(a_status_single, i_clk, i_rst_n, o_out.valid && (o_out.outcome != OUTC_XFER), o_out.last && (o_out.nibble == '0) && !o_out.register_select, "bad status word")
    // The column stays within the parked value and the line within 1 to LINES.
    `LCDNW_ASSERT_IMPL(a_col_range, i_clk, i_rst_n, o_out.valid, (r_col <= COL_PARK) && (r_line <= LINE_MAX) && (r_line != '0), "cursor out of range")

endmodule

FILE: test/tb_text_lcd_cursor_nibble_writer_core.sv
module tb_text_lcd_cursor_nibble_writer_core;
    import lcdnw_pkg::*;

    localparam int COLS = DEF_COLUMNS;
    localparam int ROWS = DEF_LINES;
    localparam int TABW = DEF_TAB_WIDTH;
    localparam int PARKED = COLS + 1;
    localparam int PHASE_ITEMS = 90;

    // One output word as it leaves the block.
    typedef struct packed {
        logic [NIB_W-1:0]  nibble;
        logic              rs;
        logic [OUTC_W-1:0] outcome;
        logic              last;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  column;
    } t_word;

    // One stimulus row; n_fixed > 0 means the expected words are written out by hand.
    typedef struct {
        t_op               op;
        logic [CODE_W-1:0] code;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  column;
        int                n_fixed;
        logic [NIB_W-1:0]  hi;
        logic [NIB_W-1:0]  lo;
        logic              rs;
        t_outcome          oc;
        logic [LINE_W-1:0] exp_line;
        logic [COL_W-1:0]  exp_column;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [ADDR_W-1:0] i_cfg_data;

    lcdnw_in_if  in_ch ();
    lcdnw_out_if out_ch ();

    text_lcd_cursor_nibble_writer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Predicted display state and the words still owed by the block.
    logic [ADDR_W-1:0] line_base [4];
    int unsigned cur_line;
    int unsigned cur_col;
    t_word step_words [$];
    t_word pending_words [$];
    t_row dir_rows [$];
    t_row cur_row;
    int mismatches;
    bit no_stall;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Receiver stalls at random unless a steady stretch is running.
    always @(negedge i_clk) begin
        out_ch.ready = no_stall ? 1'b1 : ($urandom_range(99) >= 21);
    end

    // Appends the two nibble words of one byte.
    function automatic void push_byte(input logic rs, input logic [CODE_W-1:0] b);
        t_word w;
        w = '0;
        w.rs = rs;
        w.outcome = OUTC_XFER;
        w.nibble = b[7:4];
        step_words.push_back(w);
        w.nibble = b[3:0];
        step_words.push_back(w);
    endfunction

    // Appends a single status word with empty bus fields.
    function automatic void push_status(input t_outcome oc);
        t_word w;
        w = '0;
        w.outcome = oc;
        step_words.push_back(w);
    endfunction

    // Moves the cursor or parks it when the request is out of range.
    function automatic void move_cursor(input int unsigned y, input int unsigned x);
        logic [ADDR_W-1:0] addr;
        bit line_ok;
        line_ok = (y >= 1) && (y <= ROWS);
        if (line_ok && x >= 1 && x <= COLS) begin
            addr = line_base[y-1] + ADDR_W'(x - 1);
            cur_line = y;
            cur_col = x;
            push_byte(1'b0, CMD_SET_ADDR | {1'b0, addr});
        end else begin
            cur_line = line_ok ? y : ROWS;
            cur_col = PARKED;
            push_status(OUTC_REJECT);
        end
    endfunction

    // Works out the words that one accepted item causes and updates the cursor.
    function automatic void predict_item(input t_op op, input logic [CODE_W-1:0] code,
                                         input logic [LINE_W-1:0] y,
                                         input logic [COL_W-1:0] x);
        step_words.delete();
        if (op == OP_CURSOR) begin
            move_cursor(y, x);
        end else if (op == OP_RAW) begin
            push_byte(1'b0, code);
        end else if (op == OP_PRINT) begin
            if (code == CHAR_NEWLINE) begin
                move_cursor(cur_line + 1, 1);
            end else begin
                if (code == CHAR_TAB) begin
                    if (cur_col + TABW <= COLS) begin
                        repeat (TABW) push_byte(1'b1, CHAR_SPACE);
                        cur_col += TABW;
                    end else begin
                        push_status(OUTC_CLIP);
                    end
                end else if (cur_col <= COLS) begin
                    push_byte(1'b1, code);
                    cur_col++;
                end else begin
                    push_status(OUTC_CLIP);
                end
                if (cur_col > COLS) cur_col = PARKED;
            end
        end
    endfunction

    // Queues the expected words for the item just taken, hand-written or predicted.
    function automatic void take_item();
        t_word w;
        predict_item(t_op'(in_ch.operation), in_ch.char_code, in_ch.target_line,
                     in_ch.target_column);
        for (int i = 0; i < step_words.size(); i++) begin
            step_words[i].line = LINE_W'(cur_line);
            step_words[i].column = COL_W'(cur_col);
            step_words[i].last = (i == step_words.size() - 1);
        end
        if (cur_row.n_fixed != 0) begin
            step_words.delete();
            w = '0;
            w.line = cur_row.exp_line;
            w.column = cur_row.exp_column;
            if (cur_row.n_fixed == 2) begin
                w.rs = cur_row.rs;
                w.outcome = OUTC_XFER;
                w.nibble = cur_row.hi;
                step_words.push_back(w);
                w.nibble = cur_row.lo;
            end else begin
                w.outcome = cur_row.oc;
            end
            w.last = 1'b1;
            step_words.push_back(w);
        end
        foreach (step_words[i]) pending_words.push_back(step_words[i]);
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Output check, register tracking and prediction, all on the rising edge.
    always @(posedge i_clk) begin : watch_edges
        t_word got;
        t_word want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.nibble, out_ch.register_select, out_ch.outcome, out_ch.last,
                       out_ch.cursor_line, out_ch.cursor_column};
                if (pending_words.size() == 0) begin
                    $display("%0t: word with nothing expected, expected none, actual %h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = pending_words.pop_front();
                    check_field("nibble", want.nibble, got.nibble);
                    check_field("register_select", want.rs, got.rs);
                    check_field("outcome", want.outcome, got.outcome);
                    check_field("last", want.last, got.last);
                    check_field("cursor_line", want.line, got.line);
                    check_field("cursor_column", want.column, got.column);
                end
            end
            if (i_cfg_we) line_base[i_cfg_idx] = i_cfg_data;
            if (in_ch.valid && in_ch.ready) take_item();
        end
    end

    function automatic t_row make_row(input t_op op, input logic [CODE_W-1:0] code,
                                      input logic [LINE_W-1:0] ln,
                                      input logic [COL_W-1:0] cl, input int n,
                                      input logic [NIB_W-1:0] hi,
                                      input logic [NIB_W-1:0] lo, input logic rs,
                                      input t_outcome oc, input logic [LINE_W-1:0] eln,
                                      input logic [COL_W-1:0] ecl);
        t_row r;
        r.op = op;
        r.code = code;
        r.line = ln;
        r.column = cl;
        r.n_fixed = n;
        r.hi = hi;
        r.lo = lo;
        r.rs = rs;
        r.oc = oc;
        r.exp_line = eln;
        r.exp_column = ecl;
        return r;
    endfunction

    // Offers one word to the block, with random idle cycles ahead of it.
    task automatic send_word(input t_row r);
        while (!no_stall && $urandom_range(99) < 21) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        cur_row = r;
        in_ch.valid = 1'b1;
        in_ch.operation = r.op;
        in_ch.char_code = r.code;
        in_ch.target_line = r.line;
        in_ch.target_column = r.column;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    // Waits until every expected word has come, then lets the block go quiet.
    task automatic settle();
        in_ch.valid = 1'b0;
        while (pending_words.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_base(input t_reg idx, input logic [ADDR_W-1:0] value);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Random items: mostly prints and valid cursor moves, some noise.
    task automatic send_random(input int count);
        t_row r;
        int roll;
        int sent;
        sent = 0;
        while (sent < count) begin
            r = make_row(OP_PRINT, 8'($urandom_range(255)), 3'($urandom_range(7)),
                         5'($urandom_range(31)), 0, 0, 0, 0, OUTC_XFER, 0, 0);
            roll = $urandom_range(99);
            if (roll < 45) begin
                roll = $urandom_range(99);
                if (roll < 15) r.code = CHAR_NEWLINE;
                else if (roll < 30) r.code = CHAR_TAB;
            end else if (roll < 70) begin
                r.op = OP_CURSOR;
                if ($urandom_range(99) < 75) begin
                    r.line = 3'($urandom_range(ROWS, 1));
                    r.column = 5'($urandom_range(COLS, 1));
                end
            end else if (roll < 90) begin
                r.op = OP_RAW;
            end else begin
                r.op = OP_NONE;
            end
            send_word(r);
            if (r.op != OP_NONE) sent++;
            if (sent == count / 2) settle();
        end
    endtask

    // Writes all four line bases once the block is idle, then runs random items.
    task automatic run_phase(input logic [ADDR_W-1:0] b1, input logic [ADDR_W-1:0] b2,
                             input logic [ADDR_W-1:0] b3, input logic [ADDR_W-1:0] b4,
                             input bit steady);
        settle();
        write_base(REG_LINE_ONE, b1);
        write_base(REG_LINE_TWO, b2);
        write_base(REG_LINE_THREE, b3);
        write_base(REG_LINE_FOUR, b4);
        no_stall = steady;
        send_random(PHASE_ITEMS);
        no_stall = 1'b0;
    endtask

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        mismatches = 0;
        no_stall = 1'b0;
        cur_line = 1;
        cur_col = 1;
        line_base[REG_LINE_ONE] = BASE_ONE_RST;
        line_base[REG_LINE_TWO] = BASE_TWO_RST;
        line_base[REG_LINE_THREE] = BASE_THREE_RST;
        line_base[REG_LINE_FOUR] = BASE_FOUR_RST;
        cur_row = make_row(OP_NONE, 0, 0, 0, 0, 0, 0, 0, OUTC_XFER, 0, 0);
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_LINE_ONE;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_NONE;
        in_ch.char_code = '0;
        in_ch.target_line = '0;
        in_ch.target_column = '0;
        out_ch.ready = 1'b0;

        // Directed rows: extremes, every operation, clipping, parking and rejects.
        dir_rows.push_back(make_row(OP_RAW, 8'hff, 0, 0, 2, 4'hf, 4'hf, 0, OUTC_XFER, 1, 1));
        dir_rows.push_back(make_row(OP_RAW, 8'h00, 7, 31, 2, 4'h0, 4'h0, 0, OUTC_XFER, 1, 1));
        dir_rows.push_back(make_row(OP_CURSOR, 0, 1, 1, 2, 4'h8, 4'h0, 0, OUTC_XFER, 1, 1));
        dir_rows.push_back(make_row(OP_CURSOR, 0, 4, 20, 2, 4'he, 4'h7, 0, OUTC_XFER, 4, 20));
        dir_rows.push_back(make_row(OP_PRINT, 8'hff, 0, 0, 2, 4'hf, 4'hf, 1, OUTC_XFER, 4, 21));
        dir_rows.push_back(make_row(OP_PRINT, 8'h41, 0, 0, 1, 0, 0, 0, OUTC_CLIP, 4, 21));
        dir_rows.push_back(make_row(OP_PRINT, CHAR_TAB, 0, 0, 1, 0, 0, 0, OUTC_CLIP, 4, 21));
        dir_rows.push_back(make_row(OP_PRINT, CHAR_NEWLINE, 0, 0, 1, 0, 0, 0, OUTC_REJECT,
                                    4, 21));
        dir_rows.push_back(make_row(OP_CURSOR, 0, 0, 5, 1, 0, 0, 0, OUTC_REJECT, 4, 21));
        dir_rows.push_back(make_row(OP_CURSOR, 0, 2, 0, 1, 0, 0, 0, OUTC_REJECT, 2, 21));
        dir_rows.push_back(make_row(OP_CURSOR, 0, 7, 31, 1, 0, 0, 0, OUTC_REJECT, 4, 21));
        dir_rows.push_back(make_row(OP_CURSOR, 0, 3, 21, 1, 0, 0, 0, OUTC_REJECT, 3, 21));
        dir_rows.push_back(make_row(OP_CURSOR, 0, 2, 1, 2, 4'hc, 4'h0, 0, OUTC_XFER, 2, 1));
        dir_rows.push_back(make_row(OP_PRINT, CHAR_TAB, 0, 0, 0, 0, 0, 0, OUTC_XFER, 0, 0));
        dir_rows.push_back(make_row(OP_PRINT, 8'h00, 0, 0, 0, 0, 0, 0, OUTC_XFER, 0, 0));
        dir_rows.push_back(make_row(OP_PRINT, CHAR_NEWLINE, 0, 0, 2, 4'h9, 4'h4, 0, OUTC_XFER,
                                    3, 1));
        dir_rows.push_back(make_row(OP_CURSOR, 0, 1, 17, 0, 0, 0, 0, OUTC_XFER, 0, 0));
        dir_rows.push_back(make_row(OP_PRINT, CHAR_TAB, 0, 0, 1, 0, 0, 0, OUTC_CLIP, 1, 17));
        dir_rows.push_back(make_row(OP_CURSOR, 0, 1, 16, 0, 0, 0, 0, OUTC_XFER, 0, 0));
        dir_rows.push_back(make_row(OP_PRINT, CHAR_TAB, 0, 0, 0, 0, 0, 0, OUTC_XFER, 0, 0));
        dir_rows.push_back(make_row(OP_NONE, 8'hff, 7, 31, 0, 0, 0, 0, OUTC_XFER, 0, 0));
        dir_rows.push_back(make_row(OP_PRINT, 8'h7a, 0, 0, 0, 0, 0, 0, OUTC_XFER, 0, 0));
        dir_rows.push_back(make_row(OP_PRINT, CHAR_NEWLINE, 0, 0, 0, 0, 0, 0, OUTC_XFER, 0, 0));
        dir_rows.push_back(make_row(OP_RAW, 8'ha5, 0, 0, 0, 0, 0, 0, OUTC_XFER, 0, 0));

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) send_word(dir_rows[i]);

        // Base address settings: both extremes, a mixed one and random ones.
        run_phase(7'd127, 7'd127, 7'd127, 7'd127, 1'b0);
        run_phase(7'd0, 7'd0, 7'd0, 7'd0, 1'b1);
        run_phase(7'd127, 7'd0, 7'd127, 7'd0, 1'b0);
        run_phase(7'($urandom_range(127)), 7'($urandom_range(127)),
                  7'($urandom_range(127)), 7'($urandom_range(127)), 1'b0);
        run_phase(7'($urandom_range(127)), 7'($urandom_range(127)),
                  7'($urandom_range(127)), 7'($urandom_range(127)), 1'b0);

        settle();
        repeat (20) @(negedge i_clk);
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+sv
sv/lcdnw_pkg.sv
sv/lcdnw_in_if.sv
sv/lcdnw_out_if.sv
sv/text_lcd_cursor_nibble_writer_core.sv
test/tb_text_lcd_cursor_nibble_writer_core.sv
